FILE: rtl/core/fcpl_pkg.sv
// Package for the framed command parser: status codes and framing characters.
// Used by framed_command_parser_led, its checker and the testbench; depends on nothing else.
`default_nettype none

package fcpl_pkg;

    typedef enum logic [1:0] {
        STATUS_NONE = 2'd0,
        STATUS_OK   = 2'd1,
        STATUS_ERR  = 2'd2
    } status_t;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_L      = 8'h4C;
    localparam logic [7:0] CHAR_3      = 8'h33;
    localparam logic [7:0] CHAR_4      = 8'h34;
    localparam logic [7:0] CHAR_0      = 8'h30;
    localparam logic [7:0] CHAR_1      = 8'h31;

endpackage

`default_nettype wire

FILE: rtl/core/framed_command_parser_led.sv
// Top level of the framed command parser that drives two LED levels.
// Depends on fcpl_pkg for status codes and framing characters.
`default_nettype none

// Parses frames of the form $TT,P* one received byte per request. Type L3 or
// L4 with payload 0 or 1 clears or sets the first or second LED. Every byte
// gives one result with a status code and both LED levels after that byte.
// The parser state and the result register are updated at the edge that
// accepts the byte, so one byte is accepted every cycle as long as the
// result register is empty or its result is taken in the same cycle. The
// result is shown in the cycle after its byte is accepted.
module framed_command_parser_led (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [7:0]        rx_byte,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output fcpl_pkg::status_t      status,
    output logic                   led_a,
    output logic                   led_b
);
    import fcpl_pkg::*;

    typedef enum logic [1:0] {
        PH_WAIT    = 2'd0,
        PH_TYPE    = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  type_chars_reg [2];
    logic [7:0]  type_char0_next, type_char1_next;
    logic [1:0]  type_count_reg, type_count_next;
    logic [7:0]  payload_char_reg, payload_char_next;
    logic        payload_count_reg, payload_count_next;
    logic        led_a_reg, led_a_next;
    logic        led_b_reg, led_b_next;
    status_t     status_reg, status_next;
    logic        out_valid_reg;
    logic        accept;
    logic        frame_ok;
    logic        level;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign led_a     = led_a_reg;
    assign led_b     = led_b_reg;

    always_comb
    begin
        frame_ok = (type_count_reg[1] == 1'b1) && (type_chars_reg[0] == CHAR_L)
                && payload_count_reg
                && (payload_char_reg inside {CHAR_0, CHAR_1})
                && (type_chars_reg[1] inside {CHAR_3, CHAR_4});
        level = (payload_char_reg == CHAR_1);

        phase_next         = phase_reg;
        type_char0_next    = type_chars_reg[0];
        type_char1_next    = type_chars_reg[1];
        type_count_next    = type_count_reg;
        payload_char_next  = payload_char_reg;
        payload_count_next = payload_count_reg;
        led_a_next         = led_a_reg;
        led_b_next         = led_b_reg;
        status_next        = STATUS_NONE;

        case (phase_reg)
            PH_TYPE:
            begin
                if (rx_byte == CHAR_COMMA)
                begin
                    phase_next         = PH_PAYLOAD;
                    payload_count_next = 1'b0;
                end
                else if (type_count_reg[1])
                begin
                    phase_next      = PH_WAIT;
                    type_count_next = 2'd0;
                    status_next     = STATUS_ERR;
                end
                else
                begin
                    if (type_count_reg[0])
                    begin
                        type_char1_next = rx_byte;
                    end
                    else
                    begin
                        type_char0_next = rx_byte;
                    end
                    type_count_next = type_count_reg + 2'd1;
                end
            end
            PH_PAYLOAD:
            begin
                if (rx_byte == CHAR_STAR)
                begin
                    phase_next = PH_WAIT;
                    if (frame_ok)
                    begin
                        status_next = STATUS_OK;
                        if (type_chars_reg[1] == CHAR_3)
                        begin
                            led_a_next = level;
                        end
                        else
                        begin
                            led_b_next = level;
                        end
                    end
                    else
                    begin
                        status_next = STATUS_ERR;
                    end
                end
                else if (payload_count_reg)
                begin
                    phase_next         = PH_WAIT;
                    payload_count_next = 1'b0;
                    status_next        = STATUS_ERR;
                end
                else
                begin
                    payload_char_next  = rx_byte;
                    payload_count_next = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_WAIT;
                if (rx_byte == CHAR_DOLLAR)
                begin
                    phase_next      = PH_TYPE;
                    type_count_next = 2'd0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_WAIT;
            type_chars_reg[0] <= 8'd0;
            type_chars_reg[1] <= 8'd0;
            type_count_reg    <= 2'd0;
            payload_char_reg  <= 8'd0;
            payload_count_reg <= 1'b0;
            led_a_reg         <= 1'b0;
            led_b_reg         <= 1'b0;
            status_reg        <= STATUS_NONE;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg         <= phase_next;
                type_chars_reg[0] <= type_char0_next;
                type_chars_reg[1] <= type_char1_next;
                type_count_reg    <= type_count_next;
                payload_char_reg  <= payload_char_next;
                payload_count_reg <= payload_count_next;
                led_a_reg         <= led_a_next;
                led_b_reg         <= led_b_next;
                status_reg        <= status_next;
                out_valid_reg     <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/fcpl_checker.sv
// Port-level checker for framed_command_parser_led, attached by a bind below.
// Depends on fcpl_pkg for the status codes.
`default_nettype none

module fcpl_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire fcpl_pkg::status_t status,
    input wire logic              led_a,
    input wire logic              led_b
);
    import fcpl_pkg::*;

    logic prev_a_reg;
    logic prev_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_a_reg <= 1'b0;
            prev_b_reg <= 1'b0;
        end
        else if (out_valid && out_ready)
        begin
            prev_a_reg <= led_a;
            prev_b_reg <= led_b;
        end
    end

    // A result that is not an accepted command leaves both LEDs as they were.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != STATUS_OK) |-> (led_a == prev_a_reg) && (led_b == prev_b_reg))
        else $error("LED level changed without an accepted command");

    // One command drives only one LED.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !((led_a != prev_a_reg) && (led_b != prev_b_reg)))
        else $error("both LED levels changed in one result");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STATUS_NONE) || (status == STATUS_OK)
                      || (status == STATUS_ERR))
        else $error("undefined status code");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(led_a)
                                    && $stable(led_b))
        else $error("stalled result changed");

endmodule

bind framed_command_parser_led fcpl_checker u_fcpl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .led_a     (led_a),
    .led_b     (led_b)
);

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking bench for framed_command_parser_led: byte stream in, status and LED levels out.
// It predicts each result in SystemVerilog from the parser's framing rules.
// Depends on fcpl_pkg and the framed_command_parser_led RTL.
`default_nettype none

module testbench;

    import fcpl_pkg::*;

    localparam int RANDOM_BYTES = 2000;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 4;

    typedef enum logic [1:0] {
        FRAME_IDLE    = 2'd0,
        FRAME_TYPE    = 2'd1,
        FRAME_PAYLOAD = 2'd2,
        FRAME_SPARE   = 2'd3
    } frame_phase_t;

    typedef struct {
        status_t status;
        logic    led_a;
        logic    led_b;
    } led_result_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] rx_byte   = 8'h00;
    logic       out_ready = 1'b0;
    logic       in_ready;
    logic       out_valid;
    status_t    status;
    logic       led_a;
    logic       led_b;

    logic [7:0]  tx_bytes[$];
    led_result_t expected_results[$];

    int total_bytes    = 0;
    int accepted_count = 0;
    int error_count    = 0;
    int idle_cycles    = 0;
    int send_gap       = 0;
    int send_calm      = 0;
    int stall_left     = 0;
    int stall_calm     = 0;

    frame_phase_t frame_phase   = FRAME_IDLE;
    logic [7:0]   type_chars[2] = '{8'h00, 8'h00};
    logic [1:0]   type_count    = 2'd0;
    logic [7:0]   payload_char  = 8'h00;
    logic         payload_count = 1'b0;
    logic         led_a_level   = 1'b0;
    logic         led_b_level   = 1'b0;

    framed_command_parser_led u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .led_a     (led_a),
        .led_b     (led_b)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic status_t run_command();
        logic level;
        if (type_count != 2'd2 || type_chars[0] != CHAR_L || payload_count != 1'b1)
            return STATUS_ERR;
        if (payload_char == CHAR_0)
            level = 1'b0;
        else if (payload_char == CHAR_1)
            level = 1'b1;
        else
            return STATUS_ERR;
        if (type_chars[1] == CHAR_3)
            led_a_level = level;
        else if (type_chars[1] == CHAR_4)
            led_b_level = level;
        else
            return STATUS_ERR;
        return STATUS_OK;
    endfunction

    function automatic led_result_t predict_result(logic [7:0] b);
        led_result_t r;
        r.status = STATUS_NONE;
        case (frame_phase)
            FRAME_TYPE:
            begin
                if (b == CHAR_COMMA)
                begin
                    frame_phase   = FRAME_PAYLOAD;
                    payload_count = 1'b0;
                end
                else if (type_count >= 2'd2)
                begin
                    frame_phase = FRAME_IDLE;
                    type_count  = 2'd0;
                    r.status    = STATUS_ERR;
                end
                else
                begin
                    type_chars[type_count[0]] = b;
                    type_count                = type_count + 2'd1;
                end
            end
            FRAME_PAYLOAD:
            begin
                if (b == CHAR_STAR)
                begin
                    frame_phase = FRAME_IDLE;
                    r.status    = run_command();
                end
                else if (payload_count)
                begin
                    frame_phase   = FRAME_IDLE;
                    payload_count = 1'b0;
                    r.status      = STATUS_ERR;
                end
                else
                begin
                    payload_char  = b;
                    payload_count = 1'b1;
                end
            end
            default:
            begin
                frame_phase = FRAME_IDLE;
                if (b == CHAR_DOLLAR)
                begin
                    frame_phase = FRAME_TYPE;
                    type_count  = 2'd0;
                end
            end
        endcase
        r.led_a = led_a_level;
        r.led_b = led_b_level;
        return r;
    endfunction

    function automatic int pick_gap(inout int calm_left);
        int roll;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 2)
        begin
            calm_left = $urandom_range(30, 80);
            return 0;
        end
        if (roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_char();
        logic [7:0] specials[8];
        specials = '{CHAR_DOLLAR, CHAR_COMMA, CHAR_STAR, CHAR_L,
                     CHAR_3, CHAR_4, CHAR_0, CHAR_1};
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(0, 255));
        return specials[$urandom_range(0, 7)];
    endfunction

    function automatic logic [7:0] pick_plain_char(logic [7:0] avoid);
        logic [7:0] c;
        c = pick_char();
        while (c == avoid)
            c = pick_char();
        return c;
    endfunction

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            tx_bytes.push_back(s[i]);
    endtask

    task automatic push_random_frame();
        int kind;
        int n;
        kind = $urandom_range(0, 99);
        if (kind < 5)
        begin
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++)
                tx_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        tx_bytes.push_back(CHAR_DOLLAR);
        if (kind < 60)
        begin
            tx_bytes.push_back(CHAR_L);
            tx_bytes.push_back($urandom_range(0, 1) ? CHAR_4 : CHAR_3);
            tx_bytes.push_back(CHAR_COMMA);
            tx_bytes.push_back($urandom_range(0, 1) ? CHAR_1 : CHAR_0);
            tx_bytes.push_back(CHAR_STAR);
        end
        else if (kind < 80)
        begin
            n = $urandom_range(0, 2);
            for (int i = 0; i < n; i++)
                tx_bytes.push_back(pick_plain_char(CHAR_COMMA));
            tx_bytes.push_back(CHAR_COMMA);
            if ($urandom_range(0, 3) != 0)
                tx_bytes.push_back(pick_plain_char(CHAR_STAR));
            tx_bytes.push_back(CHAR_STAR);
        end
        else if (kind < 90)
        begin
            for (int i = 0; i < 3; i++)
                tx_bytes.push_back(pick_plain_char(CHAR_COMMA));
        end
        else
        begin
            tx_bytes.push_back(CHAR_L);
            tx_bytes.push_back(pick_plain_char(CHAR_COMMA));
            tx_bytes.push_back(CHAR_COMMA);
            tx_bytes.push_back(pick_plain_char(CHAR_STAR));
            tx_bytes.push_back(pick_plain_char(CHAR_STAR));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                expected_results.push_back(predict_result(rx_byte));
                void'(tx_bytes.pop_front());
                accepted_count++;
                send_gap = pick_gap(send_calm);
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (tx_bytes.size() > 0)
                begin
                    in_valid <= 1'b1;
                    rx_byte  <= tx_bytes[0];
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no request pending: status %0d", status);
                    error_count++;
                end
                else
                begin
                    led_result_t want;
                    want = expected_results.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status expected %0d actual %0d", want.status, status);
                        error_count++;
                    end
                    if (led_a !== want.led_a)
                    begin
                        $error("led_a expected %0d actual %0d", want.led_a, led_a);
                        error_count++;
                    end
                    if (led_b !== want.led_b)
                    begin
                        $error("led_b expected %0d actual %0d", want.led_b, led_b);
                        error_count++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap(stall_calm);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("framed_command_parser_led test failed");
                $finish;
            end
        end
    end

    initial
    begin
        tx_bytes.push_back(8'h00);
        tx_bytes.push_back(8'hFF);
        push_text("$L3,1*");
        push_text("$L4,1*");
        push_text("$L3,0*");
        push_text("$LLL");
        push_text("$L4,00");
        tx_bytes.push_back(CHAR_DOLLAR);
        tx_bytes.push_back(8'h00);
        push_text(",1*");
        push_text("$L4,*");
        push_text("$L$,$*");
        while (tx_bytes.size() < RANDOM_BYTES + 46)
            push_random_frame();
        total_bytes = tx_bytes.size();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_count < total_bytes || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_results.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("framed_command_parser_led test passed");
        else
            $display("framed_command_parser_led test failed");
        $finish;
    end

endmodule

`default_nettype wire
